[sv/mpid_pkg.sv]
// ----------------------------------------------------------------------------
// mpid_pkg
// Shared types and fixed constants of the mecanum wheel speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mpid_pkg;

   localparam int NUM_WHEELS  = 4;
   localparam int WHEEL_IDX_W = 2;
   localparam int GAIN_W      = 24;
   localparam int LIMIT_W     = 15;
   localparam int MOVE_W      = 12;
   localparam int TGT_W       = 14;
   localparam int DRIVE_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 3'd4;

   localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 15'd200;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd4599;

   // opcodes
   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_I,
      ST_MUL_P,
      ST_MUL_D,
      ST_ADD_D,
      ST_ADD_I,
      ST_CLAMP,
      ST_OUT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      GS_PROP,
      GS_INTEG,
      GS_DERIV
   } gain_sel_type;

   typedef struct packed {
      logic         mul_en;
      gain_sel_type gain_sel;
      logic         use_diff;
   } mul_ctrl_type;

endpackage

`default_nettype wire

[sv/mpid_req_if.sv]
// ----------------------------------------------------------------------------
// mpid_req_if
// Request channel: motion commands and control ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpid_req_if #(
   parameter int ENC_WIDTH = 16
) ();
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic signed [11:0]          move_y;
   logic signed [11:0]          move_x;
   logic signed [11:0]          yaw_rate;
   logic signed [ENC_WIDTH-1:0] enc_count_a;
   logic signed [ENC_WIDTH-1:0] enc_count_b;
   logic signed [ENC_WIDTH-1:0] enc_count_c;
   logic signed [ENC_WIDTH-1:0] enc_count_d;

   modport source (
      output valid, opcode, move_y, move_x, yaw_rate,
             enc_count_a, enc_count_b, enc_count_c, enc_count_d,
      input  ready
   );

   modport sink (
      input  valid, opcode, move_y, move_x, yaw_rate,
             enc_count_a, enc_count_b, enc_count_c, enc_count_d,
      output ready
   );
endinterface

`default_nettype wire

[sv/mpid_rsp_if.sv]
// ----------------------------------------------------------------------------
// mpid_rsp_if
// Response channel: four wheel drive values.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpid_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [15:0] drive_a;
   logic signed [15:0] drive_b;
   logic signed [15:0] drive_c;
   logic signed [15:0] drive_d;

   modport source (
      output valid, drive_a, drive_b, drive_c, drive_d,
      input  ready
   );

   modport sink (
      input  valid, drive_a, drive_b, drive_c, drive_d,
      output ready
   );
endinterface

`default_nettype wire

[sv/mpid_mul.sv]
// ----------------------------------------------------------------------------
// mpid_mul
// Shared gain multiplier: unsigned gain times signed operand, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mpid_mul #(
   parameter int B_W = 18
) (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic [mpid_pkg::GAIN_W-1:0]            gain,
   input  wire logic signed [B_W-1:0]                  operand,
   output      logic signed [B_W+mpid_pkg::GAIN_W:0]   prod
);

   logic signed [B_W+mpid_pkg::GAIN_W:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= signed'({1'b0, gain}) * operand;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

[sv/four_wheel_mecanum_pid_speed.sv]
// ----------------------------------------------------------------------------
// four_wheel_mecanum_pid_speed
// Four-wheel mecanum speed controller with shared-gain PID per wheel.
// ----------------------------------------------------------------------------
// usage
//   req_if: one beat per item. opcode move sets the four wheel targets from
//     move_y, move_x and yaw_rate in registers and returns no beat.
//     opcode tick carries four encoder speeds and returns one rsp_if beat
//     with four drive values.
//   csr_*: write-only register port (gains, integral and drive limits),
//     written by the user only while the block is idle (not enforced).
// sequencing
//   a tick walks the four wheels in turn through one shared multiplier,
//   eight sequencer steps per wheel (error, three products, adds, clamps,
//   output truncation), then a hand-off step loads the result beat. no
//   item is taken while a tick runs; a new one can be taken in the cycle
//   in which the result beat becomes valid.
// reset
//   synchronous, active high: gains and limits go to their defaults, all
//   targets, previous errors and accumulators go to zero, no beat is pending.
// stall
//   the result sits in an output register until rsp_if.ready; while idle
//   the block stays ready for commands meanwhile, and a tick that finishes
//   while the previous beat is still held waits in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module four_wheel_mecanum_pid_speed #(
   parameter int FRAC_BITS = 12,
   parameter int ENC_WIDTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mpid_req_if.sink                                req_if,
   mpid_rsp_if.source                              rsp_if,
   input  wire logic                               csr_we,
   input  wire logic [mpid_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  wire logic [mpid_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // widths derived from the parameters
   localparam int ERR_W  = ((ENC_WIDTH > mpid_pkg::TGT_W) ? ENC_WIDTH : mpid_pkg::TGT_W) + 1;
   localparam int DIFF_W = ERR_W + 1;
   localparam int PROD_W = DIFF_W + mpid_pkg::GAIN_W + 1;
   localparam int ACC_W  = mpid_pkg::LIMIT_W + FRAC_BITS + 1;
   localparam int SUM_W  = PROD_W + 3;
   localparam int NW     = mpid_pkg::NUM_WHEELS;
   localparam int IW     = mpid_pkg::WHEEL_IDX_W;
   localparam int GW     = mpid_pkg::GAIN_W;
   localparam int LW     = mpid_pkg::LIMIT_W;
   localparam int DW     = mpid_pkg::DRIVE_W;
   localparam int TW     = mpid_pkg::TGT_W;

   // reset gains: 16.0 and about 0.2 in this fraction format
   localparam logic [GW-1:0] PROP_GAIN_RST  = GW'(16 << FRAC_BITS);
   localparam logic [GW-1:0] DERIV_GAIN_RST = GW'((1 << FRAC_BITS) / 5);

   // ---------------------------------------------------------------------
   // symmetric clamp of a wide sum to +-(limit whole units)
   function automatic logic signed [ACC_W-1:0] clamp_acc(
      input logic signed [SUM_W-1:0] v,
      input logic [LW-1:0]           lim
   );
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      logic signed [SUM_W-1:0] r;
      hi = signed'({{(SUM_W-ACC_W+1){1'b0}}, lim, {FRAC_BITS{1'b0}}});
      lo = -hi;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r[ACC_W-1:0];
   endfunction

   // accumulator to whole units, truncated toward zero
   function automatic logic signed [DW-1:0] to_whole(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] shf;
      logic [DW-1:0]    whole;
      mag   = v[ACC_W-1] ? ACC_W'(-v) : v;
      shf   = mag >> FRAC_BITS;
      whole = shf[DW-1:0];
      return v[ACC_W-1] ? signed'(-whole) : signed'(whole);
   endfunction

   // ---------------------------------------------------------------------
   // configuration registers
   logic [GW-1:0] prop_gain_ff;
   logic [GW-1:0] integ_gain_ff;
   logic [GW-1:0] deriv_gain_ff;
   logic [LW-1:0] integ_limit_ff;
   logic [LW-1:0] drive_limit_ff;

   // per-wheel state
   logic signed [TW-1:0]    target_ff [NW];
   logic signed [ERR_W-1:0] prev_err_ff [NW];
   logic signed [ACC_W-1:0] integ_ff [NW];
   logic signed [ACC_W-1:0] drive_acc_ff [NW];

   // sequencer
   mpid_pkg::state_type    state_ff;
   mpid_pkg::state_type    state_in;
   logic [IW-1:0]          ch_ff;
   mpid_pkg::mul_ctrl_type mul_ctrl;
   logic                   rsp_valid_ff;
   logic                   rsp_load;

   // working registers
   logic signed [ENC_WIDTH-1:0] enc_ff [NW];
   logic signed [ERR_W-1:0]     err_ff;
   logic signed [DIFF_W-1:0]    diff_ff;
   logic signed [SUM_W-1:0]     isum_ff;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [DW-1:0]        outw_ff [NW];
   logic signed [DW-1:0]        rsp_drive_ff [NW];

   // shared multiplier
   logic [GW-1:0]            mul_gain;
   logic signed [DIFF_W-1:0] mul_operand;
   logic signed [PROD_W-1:0] prod;

   logic req_beat;
   logic signed [TW-1:0] ty;
   logic signed [TW-1:0] tx;
   logic signed [TW-1:0] tr;

   assign req_beat = req_if.valid && req_if.ready;
   assign ty = TW'(req_if.move_y);
   assign tx = TW'(req_if.move_x);
   assign tr = TW'(req_if.yaw_rate);

   // ---------------------------------------------------------------------
   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpid_pkg::ST_IDLE: begin
            if (req_beat && (req_if.opcode == mpid_pkg::OP_TICK)) begin
               state_in = mpid_pkg::ST_ERR;
            end
         end
         mpid_pkg::ST_ERR:   state_in = mpid_pkg::ST_MUL_I;
         mpid_pkg::ST_MUL_I: state_in = mpid_pkg::ST_MUL_P;
         mpid_pkg::ST_MUL_P: state_in = mpid_pkg::ST_MUL_D;
         mpid_pkg::ST_MUL_D: state_in = mpid_pkg::ST_ADD_D;
         mpid_pkg::ST_ADD_D: state_in = mpid_pkg::ST_ADD_I;
         mpid_pkg::ST_ADD_I: state_in = mpid_pkg::ST_CLAMP;
         mpid_pkg::ST_CLAMP: state_in = mpid_pkg::ST_OUT;
         mpid_pkg::ST_OUT: begin
            state_in = (ch_ff == IW'(NW - 1)) ? mpid_pkg::ST_DONE : mpid_pkg::ST_ERR;
         end
         mpid_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = mpid_pkg::ST_IDLE;
            end
         end
         default: state_in = mpid_pkg::ST_IDLE;
      endcase
   end

   // state decode to multiplier control and handshake
   always_comb begin
      mul_ctrl.mul_en   = 1'b0;
      mul_ctrl.gain_sel = mpid_pkg::GS_PROP;
      mul_ctrl.use_diff = 1'b0;
      rsp_load          = 1'b0;
      unique case (state_ff)
         mpid_pkg::ST_MUL_I: begin
            mul_ctrl.mul_en   = 1'b1;
            mul_ctrl.gain_sel = mpid_pkg::GS_INTEG;
         end
         mpid_pkg::ST_MUL_P: begin
            mul_ctrl.mul_en   = 1'b1;
            mul_ctrl.gain_sel = mpid_pkg::GS_PROP;
         end
         mpid_pkg::ST_MUL_D: begin
            mul_ctrl.mul_en   = 1'b1;
            mul_ctrl.gain_sel = mpid_pkg::GS_DERIV;
            mul_ctrl.use_diff = 1'b1;
         end
         mpid_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_if.ready;
         end
         default: begin
         end
      endcase
   end

   assign req_if.ready = (state_ff == mpid_pkg::ST_IDLE);

   // gain and operand select for the shared multiplier
   always_comb begin
      unique case (mul_ctrl.gain_sel)
         mpid_pkg::GS_INTEG: mul_gain = integ_gain_ff;
         mpid_pkg::GS_DERIV: mul_gain = deriv_gain_ff;
         default:            mul_gain = prop_gain_ff;
      endcase
      mul_operand = mul_ctrl.use_diff ? diff_ff : DIFF_W'(err_ff);
   end

   mpid_mul #(
      .B_W (DIFF_W)
   ) u_mul (
      .clock   (clock),
      .en      (mul_ctrl.mul_en),
      .gain    (mul_gain),
      .operand (mul_operand),
      .prod    (prod)
   );

   // ---------------------------------------------------------------------
   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpid_pkg::ST_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (rsp_valid_ff && !rsp_if.ready) || rsp_load;
         if (state_ff == mpid_pkg::ST_OUT) begin
            ch_ff <= ch_ff + IW'(1);
         end
      end
   end

   // configuration set to defaults and per-wheel state cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= PROP_GAIN_RST;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= DERIV_GAIN_RST;
         integ_limit_ff <= mpid_pkg::INTEG_LIMIT_RST;
         drive_limit_ff <= mpid_pkg::DRIVE_LIMIT_RST;
         for (int i = 0; i < NW; i++) begin
            target_ff[i]    <= '0;
            prev_err_ff[i]  <= '0;
            integ_ff[i]     <= '0;
            drive_acc_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_idx)
               mpid_pkg::CSR_PROP_GAIN:   prop_gain_ff   <= csr_wdata[GW-1:0];
               mpid_pkg::CSR_INTEG_GAIN:  integ_gain_ff  <= csr_wdata[GW-1:0];
               mpid_pkg::CSR_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata[GW-1:0];
               mpid_pkg::CSR_INTEG_LIMIT: integ_limit_ff <= csr_wdata[LW-1:0];
               mpid_pkg::CSR_DRIVE_LIMIT: drive_limit_ff <= csr_wdata[LW-1:0];
               default: begin
               end
            endcase
         end
         // wheel mixing on a motion command
         if (req_beat && (req_if.opcode == mpid_pkg::OP_MOVE)) begin
            target_ff[0] <= -ty + tx + tr;
            target_ff[1] <= -ty - tx + tr;
            target_ff[2] <= ty - tx + tr;
            target_ff[3] <= ty + tx + tr;
         end
         // integral clamp while the p product goes into the drive sum
         if (state_ff == mpid_pkg::ST_MUL_D) begin
            integ_ff[ch_ff] <= clamp_acc(isum_ff, integ_limit_ff);
         end
         if (state_ff == mpid_pkg::ST_CLAMP) begin
            drive_acc_ff[ch_ff] <= clamp_acc(sum_ff, drive_limit_ff);
            prev_err_ff[ch_ff]  <= err_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         enc_ff[0] <= req_if.enc_count_a;
         enc_ff[1] <= req_if.enc_count_b;
         enc_ff[2] <= req_if.enc_count_c;
         enc_ff[3] <= req_if.enc_count_d;
      end
      case (state_ff)
         mpid_pkg::ST_ERR: begin
            // error = encoder - target
            err_ff <= ERR_W'(enc_ff[ch_ff]) - ERR_W'(target_ff[ch_ff]);
         end
         mpid_pkg::ST_MUL_I: begin
            diff_ff <= DIFF_W'(err_ff) - DIFF_W'(prev_err_ff[ch_ff]);
         end
         mpid_pkg::ST_MUL_P: begin
            // product holds the i term
            isum_ff <= SUM_W'(integ_ff[ch_ff]) + SUM_W'(prod);
         end
         mpid_pkg::ST_MUL_D: begin
            // product holds the p term
            sum_ff <= SUM_W'(drive_acc_ff[ch_ff]) + SUM_W'(prod);
         end
         mpid_pkg::ST_ADD_D: begin
            // product holds the d term
            sum_ff <= sum_ff + SUM_W'(prod);
         end
         mpid_pkg::ST_ADD_I: begin
            // freshly clamped integral
            sum_ff <= sum_ff + SUM_W'(integ_ff[ch_ff]);
         end
         mpid_pkg::ST_OUT: begin
            outw_ff[ch_ff] <= to_whole(drive_acc_ff[ch_ff]);
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         for (int i = 0; i < NW; i++) begin
            rsp_drive_ff[i] <= outw_ff[i];
         end
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.drive_a = rsp_drive_ff[0];
   assign rsp_if.drive_b = rsp_drive_ff[1];
   assign rsp_if.drive_c = rsp_drive_ff[2];
   assign rsp_if.drive_d = rsp_drive_ff[3];

   // ---------------------------------------------------------------------
`ifndef ASSERT_OFF
   // wheel counter is back at the first wheel whenever the sequencer idles
   a_ch_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpid_pkg::ST_IDLE) |-> (ch_ff == '0))
      else $error("wheel counter not at first wheel while idle");

   // a tick starts the per-wheel sequence on the next cycle
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_if.opcode == mpid_pkg::OP_TICK)) |=> (state_ff == mpid_pkg::ST_ERR))
      else $error("tick accepted but sequence did not start");

   // a result beat only appears out of the hand-off step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mpid_pkg::ST_DONE))
      else $error("result beat raised outside hand-off step");
`endif

endmodule

`default_nettype wire
